>>> src/mhs_pkg.sv
// shared types, constants and sequencing tables for the hooke stress update unit
`timescale 1ns / 1ps
package mhs_pkg;

  localparam int NUM_POINTS      = 1024;
  localparam int NODES_PER_POINT = 8;
  localparam int PT_W            = 10;
  localparam int PT_AW           = $clog2(NUM_POINTS);
  localparam int RAM_AW          = PT_AW + 3;
  localparam int RAM_DEPTH       = 2 ** RAM_AW;
  localparam int NC_W            = (NODES_PER_POINT > 1) ? $clog2(NODES_PER_POINT) : 1;
  localparam int CFG_W           = 31;
  localparam int CFG_IDX_W       = 3;
  localparam int DIV_W           = 48;
  localparam int NODE_STEPS      = 27;
  localparam int FIN_STEPS       = 25;
  localparam int IN_W            = 240;
  localparam int OUT_W           = 208;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd4;

  // stiffness selectors
  localparam logic [2:0] K_N = 3'd0;
  localparam logic [2:0] K_C = 3'd1;
  localparam logic [2:0] K_S = 3'd2;

  typedef enum logic [1:0] {
    MK_NONE = 2'd0,
    MK_VG   = 2'd1,
    MK_RDT  = 2'd2,
    MK_KE   = 2'd3
  } mul_kind_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_RATE_N   = 4'd1,
    ACT_P1       = 4'd2,
    ACT_RATE_S   = 4'd3,
    ACT_ACC      = 4'd4,
    ACT_STRAIN   = 4'd5,
    ACT_KE_FIRST = 4'd6,
    ACT_KE_ADD   = 4'd7,
    ACT_KE_LAST  = 4'd8,
    ACT_KE_ONLY  = 4'd9
  } act_t;

  typedef struct packed {
    logic              load;
    logic              div_start;
    logic              div_step;
    logic              div_end;
    logic [1:0]        vidx;
    mul_kind_t         mk;
    logic [2:0]        a_idx;
    logic [2:0]        b_idx;
    act_t              act;
    logic [2:0]        k;
    logic              ram_rd;
    logic              clr_wr;
    logic [RAM_AW-1:0] clr_addr;
    logic              put;
  } dp_cmd_t;

  typedef struct packed {
    logic mass_ok;
    logic last_node;
    logic out_full;
  } dp_stat_t;

  typedef struct packed {
    mul_kind_t  mk;
    logic [2:0] a_idx;
    logic [2:0] b_idx;
    act_t       act;
    logic [2:0] k;
    logic       ram_rd;
  } step_t;

  function automatic step_t mk_step(mul_kind_t mk, logic [2:0] a, logic [2:0] b,
                                    act_t act, logic [2:0] k, logic rd);
    step_t s;
    s.mk = mk; s.a_idx = a; s.b_idx = b; s.act = act; s.k = k; s.ram_rd = rd;
    return s;
  endfunction

  // per-node sequence: velocity-gradient products, rates, time-step scaling
  function automatic step_t node_step(logic [4:0] n);
    step_t s;
    s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_NONE, 3'd0, 1'b0);
    unique case (n)
      5'd0:  s = mk_step(MK_VG,   3'd0, 3'd0, ACT_NONE,   3'd0, 1'b0);
      5'd1:  s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_RATE_N, 3'd0, 1'b0);
      5'd2:  s = mk_step(MK_RDT,  3'd0, 3'd0, ACT_NONE,   3'd0, 1'b0);
      5'd3:  s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_ACC,    3'd0, 1'b0);
      5'd4:  s = mk_step(MK_VG,   3'd1, 3'd1, ACT_NONE,   3'd1, 1'b0);
      5'd5:  s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_RATE_N, 3'd1, 1'b0);
      5'd6:  s = mk_step(MK_RDT,  3'd0, 3'd0, ACT_NONE,   3'd1, 1'b0);
      5'd7:  s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_ACC,    3'd1, 1'b0);
      5'd8:  s = mk_step(MK_VG,   3'd2, 3'd2, ACT_NONE,   3'd2, 1'b0);
      5'd9:  s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_RATE_N, 3'd2, 1'b0);
      5'd10: s = mk_step(MK_RDT,  3'd0, 3'd0, ACT_NONE,   3'd2, 1'b0);
      5'd11: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_ACC,    3'd2, 1'b0);
      5'd12: s = mk_step(MK_VG,   3'd0, 3'd1, ACT_NONE,   3'd3, 1'b0);
      5'd13: s = mk_step(MK_VG,   3'd1, 3'd0, ACT_P1,     3'd3, 1'b0);
      5'd14: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_RATE_S, 3'd3, 1'b0);
      5'd15: s = mk_step(MK_RDT,  3'd0, 3'd0, ACT_NONE,   3'd3, 1'b0);
      5'd16: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_ACC,    3'd3, 1'b0);
      5'd17: s = mk_step(MK_VG,   3'd1, 3'd2, ACT_NONE,   3'd4, 1'b0);
      5'd18: s = mk_step(MK_VG,   3'd2, 3'd1, ACT_P1,     3'd4, 1'b0);
      5'd19: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_RATE_S, 3'd4, 1'b0);
      5'd20: s = mk_step(MK_RDT,  3'd0, 3'd0, ACT_NONE,   3'd4, 1'b0);
      5'd21: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_ACC,    3'd4, 1'b0);
      5'd22: s = mk_step(MK_VG,   3'd2, 3'd0, ACT_NONE,   3'd5, 1'b0);
      5'd23: s = mk_step(MK_VG,   3'd0, 3'd2, ACT_P1,     3'd5, 1'b0);
      5'd24: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_RATE_S, 3'd5, 1'b0);
      5'd25: s = mk_step(MK_RDT,  3'd0, 3'd0, ACT_NONE,   3'd5, 1'b0);
      5'd26: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_ACC,    3'd5, 1'b0);
      default: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_NONE, 3'd0, 1'b0);
    endcase
    return s;
  endfunction

  // point completion: strain read-modify-write, then stress products
  function automatic step_t fin_step(logic [4:0] n);
    step_t s;
    s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_NONE, 3'd0, 1'b0);
    if (n < 5'd12) begin
      if (n[0]) s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_STRAIN, n[3:1], 1'b0);
      else      s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_NONE,   n[3:1], 1'b1);
    end else begin
      unique case (n)
        5'd12: s = mk_step(MK_KE,   K_N, 3'd0, ACT_NONE,     3'd0, 1'b0);
        5'd13: s = mk_step(MK_KE,   K_C, 3'd1, ACT_KE_FIRST, 3'd0, 1'b0);
        5'd14: s = mk_step(MK_KE,   K_C, 3'd2, ACT_KE_ADD,   3'd0, 1'b0);
        5'd15: s = mk_step(MK_KE,   K_N, 3'd1, ACT_KE_LAST,  3'd0, 1'b0);
        5'd16: s = mk_step(MK_KE,   K_C, 3'd0, ACT_KE_FIRST, 3'd1, 1'b0);
        5'd17: s = mk_step(MK_KE,   K_C, 3'd2, ACT_KE_ADD,   3'd1, 1'b0);
        5'd18: s = mk_step(MK_KE,   K_N, 3'd2, ACT_KE_LAST,  3'd1, 1'b0);
        5'd19: s = mk_step(MK_KE,   K_C, 3'd0, ACT_KE_FIRST, 3'd2, 1'b0);
        5'd20: s = mk_step(MK_KE,   K_C, 3'd1, ACT_KE_ADD,   3'd2, 1'b0);
        5'd21: s = mk_step(MK_KE,   K_S, 3'd3, ACT_KE_LAST,  3'd2, 1'b0);
        5'd22: s = mk_step(MK_KE,   K_S, 3'd4, ACT_KE_ONLY,  3'd3, 1'b0);
        5'd23: s = mk_step(MK_KE,   K_S, 3'd5, ACT_KE_ONLY,  3'd4, 1'b0);
        5'd24: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_KE_ONLY, 3'd5, 1'b0);
        default: s = mk_step(MK_NONE, 3'd0, 3'd0, ACT_NONE, 3'd0, 1'b0);
      endcase
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647)       r = 32'sh7fffffff;
    else if (x < -66'sd2147483648) r = 32'sh80000000;
    else                           r = x[31:0];
    return r;
  endfunction

endpackage

>>> src/mhs_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module mhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> src/mhs_ctrl.sv
// controller: clearing pass, node sequencing, divider and point completion
`timescale 1ns / 1ps
module mhs_ctrl import mhs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_DECIDE = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_NODE   = 8'b0001_0000,
    ST_COUNT  = 8'b0010_0000,
    ST_FIN    = 8'b0100_0000,
    ST_PUT    = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [5:0]        cnt, cnt_next;
  logic [1:0]        vidx, vidx_next;
  logic [NC_W-1:0]   nodes, nodes_next;
  logic [RAM_AW-1:0] clr_addr, clr_addr_next;
  step_t             st;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    vidx_next     = vidx;
    nodes_next    = nodes;
    clr_addr_next = clr_addr;
    cmd           = '0;
    cmd.mk        = MK_NONE;
    cmd.act       = ACT_NONE;
    cmd.vidx      = vidx;
    cmd.clr_addr  = clr_addr;
    st            = mk_step(MK_NONE, 3'd0, 3'd0, ACT_NONE, 3'd0, 1'b0);
    if (state == ST_NODE) st = node_step(cnt[4:0]);
    if (state == ST_FIN)  st = fin_step(cnt[4:0]);
    cmd.mk     = st.mk;
    cmd.a_idx  = st.a_idx;
    cmd.b_idx  = st.b_idx;
    cmd.act    = st.act;
    cmd.k      = st.k;
    cmd.ram_rd = st.ram_rd;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr    = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (&clr_addr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cnt_next   = '0;
        vidx_next  = '0;
        state_next = stat.mass_ok ? ST_DIV : ST_COUNT;
      end
      ST_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 6'd0) begin
          cmd.div_start = 1'b1;
        end else if (cnt == 6'(DIV_W + 1)) begin
          cmd.div_end = 1'b1;
          cnt_next    = '0;
          vidx_next   = vidx + 1'b1;
          if (vidx == 2'd2) state_next = ST_NODE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_NODE: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 6'(NODE_STEPS - 1)) state_next = ST_COUNT;
      end
      ST_COUNT: begin
        cnt_next = '0;
        // a point closes on its mark or on its last permitted node
        if (stat.last_node || nodes == NC_W'(NODES_PER_POINT - 1)) begin
          nodes_next = '0;
          state_next = ST_FIN;
        end else begin
          nodes_next = nodes + 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FIN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 6'(FIN_STEPS - 1)) state_next = ST_PUT;
      end
      ST_PUT: begin
        if (!stat.out_full) begin
          cmd.put    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      vidx     <= '0;
      nodes    <= '0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      vidx     <= vidx_next;
      nodes    <= nodes_next;
      clr_addr <= clr_addr_next;
    end
  end

endmodule

>>> src/mhs_datapath.sv
// datapath: item registers, shared divider and multiplier, sums, strain store, output
`timescale 1ns / 1ps
module mhs_datapath import mhs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [IN_W-1:0]      in_data,
  input  logic                 in_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_data
);

  logic [CFG_W-1:0] normal_stiffness, cross_stiffness, shear_stiffness;
  logic [CFG_W-1:0] time_step, mass_threshold;

  logic [PT_W-1:0]    point;
  logic signed [31:0] mom [3];
  logic signed [31:0] grad [3];
  logic [30:0]        mass;
  logic               last;

  logic signed [31:0] vel [3];
  logic [DIV_W-1:0]   dq;
  logic [30:0]        drem;
  logic               dneg;
  logic signed [31:0] mom_sel;
  logic [31:0]        mom_abs;
  logic [32:0]        trial;
  logic signed [31:0] quot;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] p1;
  logic signed [31:0] rate;
  logic signed [31:0] sums [6];
  logic signed [31:0] strain [6];
  logic signed [65:0] stacc;
  logic signed [31:0] stress [6];
  logic signed [31:0] term;
  logic signed [31:0] strain_new;

  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic [PT_AW-1:0]   slot;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_stiffness <= '0;
      cross_stiffness  <= '0;
      shear_stiffness  <= '0;
      time_step        <= '0;
      mass_threshold   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL: normal_stiffness <= cfg_data;
        REG_CROSS:  cross_stiffness  <= cfg_data;
        REG_SHEAR:  shear_stiffness  <= cfg_data;
        REG_DT:     time_step        <= cfg_data;
        REG_THRESH: mass_threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      point   <= in_data[9:0];
      mom[0]  <= in_data[41:10];
      mom[1]  <= in_data[73:42];
      mom[2]  <= in_data[105:74];
      mass    <= in_data[136:106];
      grad[0] <= in_data[168:137];
      grad[1] <= in_data[200:169];
      grad[2] <= in_data[232:201];
      last    <= in_last;
    end
  end

  assign stat.mass_ok   = mass > mass_threshold;
  assign stat.last_node = last;
  assign stat.out_full  = out_valid && !out_ready;

  // restoring divider on |momentum| * 2^16, one quotient bit a cycle
  always_comb begin
    unique case (cmd.vidx)
      2'd0:    mom_sel = mom[0];
      2'd1:    mom_sel = mom[1];
      default: mom_sel = mom[2];
    endcase
    mom_abs = mom_sel[31] ? 32'(-mom_sel) : mom_sel;
    trial   = {1'b0, drem, dq[DIV_W-1]} - {2'b00, mass};
    if (dneg) quot = (dq > DIV_W'(64'h8000_0000)) ? 32'sh80000000 : 32'(-dq);
    else      quot = (dq > DIV_W'(64'h7fff_ffff)) ? 32'sh7fffffff : dq[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq   <= {mom_abs, 16'h0000};
      drem <= '0;
      dneg <= mom_sel[31];
    end else if (cmd.div_step) begin
      if (!trial[32]) begin
        drem <= trial[30:0];
        dq   <= {dq[DIV_W-2:0], 1'b1};
      end else begin
        drem <= {drem[29:0], dq[DIV_W-1]};
        dq   <= {dq[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.div_end) begin
      unique case (cmd.vidx)
        2'd0:    vel[0] <= quot;
        2'd1:    vel[1] <= quot;
        default: vel[2] <= quot;
      endcase
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mk)
      MK_VG: begin
        unique case (cmd.a_idx)
          3'd0:    mul_a = 33'(vel[0]);
          3'd1:    mul_a = 33'(vel[1]);
          default: mul_a = 33'(vel[2]);
        endcase
        unique case (cmd.b_idx)
          3'd0:    mul_b = 33'(grad[0]);
          3'd1:    mul_b = 33'(grad[1]);
          default: mul_b = 33'(grad[2]);
        endcase
      end
      MK_RDT: begin
        mul_a = 33'(rate);
        mul_b = {2'b00, time_step};
      end
      MK_KE: begin
        unique case (cmd.a_idx)
          K_N:     mul_a = {2'b00, normal_stiffness};
          K_C:     mul_a = {2'b00, cross_stiffness};
          default: mul_a = {2'b00, shear_stiffness};
        endcase
        unique case (cmd.b_idx)
          3'd0:    mul_b = 33'(strain[0]);
          3'd1:    mul_b = 33'(strain[1]);
          3'd2:    mul_b = 33'(strain[2]);
          3'd3:    mul_b = 33'(strain[3]);
          3'd4:    mul_b = 33'(strain[4]);
          default: mul_b = 33'(strain[5]);
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mk != MK_NONE) prod <= mul_a * mul_b;
  end

  assign term       = sat32(prod >>> 2);
  assign strain_new = sat32(66'(signed'(ram_rdata)) + 66'(sums[cmd.k]));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) sums[i] <= '0;
    end else if (cmd.put) begin
      for (int i = 0; i < 6; i++) sums[i] <= '0;
    end else if (cmd.act == ACT_ACC) begin
      sums[cmd.k] <= sat32(66'(sums[cmd.k]) + 66'(term));
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.act)
      ACT_RATE_N:   rate <= sat32(prod >>> 16);
      ACT_P1:       p1 <= prod >>> 16;
      ACT_RATE_S:   rate <= sat32((p1 + (prod >>> 16)) >>> 1);
      ACT_STRAIN:   strain[cmd.k] <= strain_new;
      ACT_KE_FIRST: stacc <= prod >>> 30;
      ACT_KE_ADD:   stacc <= stacc + (prod >>> 30);
      ACT_KE_LAST:  stress[cmd.k] <= sat32(stacc + (prod >>> 30));
      ACT_KE_ONLY:  stress[cmd.k] <= sat32(prod >>> 30);
      default: ;
    endcase
  end

  // strain store: one row of eight words per point
  assign slot      = PT_AW'(point % NUM_POINTS);
  assign ram_we    = cmd.clr_wr || (cmd.act == ACT_STRAIN);
  assign ram_waddr = cmd.clr_wr ? cmd.clr_addr : {slot, cmd.k};
  assign ram_wdata = cmd.clr_wr ? 32'h0 : strain_new;
  assign ram_raddr = {slot, cmd.k};

  mhs_ram #(
    .WIDTH(32),
    .DEPTH(RAM_DEPTH)
  ) u_strain_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ram_rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_data <= {6'h00, stress[5], stress[4], stress[3], stress[2], stress[1],
                   stress[0], point};
    end
  end

endmodule

>>> src/mpm_hooke_strain_stress_update_unit.sv
// top level of the material point hooke strain and stress update unit
`timescale 1ns / 1ps
// Takes one node of a material point per transaction. A node whose mass exceeds the
// threshold runs three momentum/mass divisions on one restoring divider (load, 48
// quotient steps, store), then its products on the single shared multiplier; a
// skipped node goes from the decision straight to the node count. The closing node
// of a point adds the strain read-modify-write on the strain ram and twelve stiffness
// products before the stress transaction is presented. After reset a clearing pass
// over all 8192 words zeroes the strain store; s_tready stays low until it ends, while
// configuration writes are taken at any time the unit is idle.
module mpm_hooke_strain_stress_update_unit import mhs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // point_index, momentum_x, momentum_y, momentum_z, node_mass, grad_x, grad_y, grad_z
  input  logic [IN_W-1:0]      s_tdata,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_point, stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_zx
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mhs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

>>> src/mhs_checker.sv
// port-level checks for the hooke stress update unit
`timescale 1ns / 1ps
module mhs_checker import mhs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // nothing leaves right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // clearing pass keeps the input closed after reset
  a_rst_in: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input open during clearing pass");

  // one node at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while a node is in work");

endmodule

bind mpm_hooke_strain_stress_update_unit mhs_checker u_mhs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/tb_mpm_hooke_strain_stress_update_unit.sv
// self-checking testbench for the hooke strain and stress update unit
`timescale 1ns / 1ps
module tb_mpm_hooke_strain_stress_update_unit;
  import mhs_pkg::*;

  typedef struct {
    logic [9:0]         pt;
    logic signed [31:0] mom [3];
    logic [30:0]        mass;
    logic signed [31:0] grad [3];
    logic               last;
  } node_t;

  typedef struct {
    logic [9:0]         pt;
    logic signed [31:0] sig [6];
  } stress_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NORMAL;
  logic [CFG_W-1:0] cfg_data = '0;

  mpm_hooke_strain_stress_update_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint unsigned k_normal, k_cross, k_shear, dt, mass_min;
  int  incr_sum [6];
  int  strain_store [NUM_POINTS][6];
  int  nodes_seen;
  node_t   node_q [$];
  stress_t stress_q [$];
  node_t   cur;
  int  errors, accepted, points_done, quiet_from, quiet_to;

  function automatic int sat(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic int shear_rate(longint va, longint gb, longint vb, longint ga);
    return sat(((va * gb >>> 16) + (vb * ga >>> 16)) >>> 1);
  endfunction

  function automatic longint kmul(longint unsigned k, int e);
    return (longint'(k) * longint'(e)) >>> 30;
  endfunction

  task automatic accumulate_node(node_t n);
    longint v [3];
    longint g [3];
    int rate [6];
    stress_t r;
    int a;
    if (n.mass > mass_min) begin
      for (int i = 0; i < 3; i++) begin
        v[i] = sat((longint'(n.mom[i]) * 65536) / longint'(n.mass));
        g[i] = n.grad[i];
      end
      for (int i = 0; i < 3; i++) rate[i] = sat(v[i] * g[i] >>> 16);
      rate[3] = shear_rate(v[0], g[1], v[1], g[0]);
      rate[4] = shear_rate(v[1], g[2], v[2], g[1]);
      rate[5] = shear_rate(v[2], g[0], v[0], g[2]);
      for (int i = 0; i < 6; i++)
        incr_sum[i] = sat(longint'(incr_sum[i]) +
                          sat((longint'(rate[i]) * longint'(dt)) >>> 2));
    end
    nodes_seen++;
    if (!n.last && nodes_seen < NODES_PER_POINT) return;
    a = n.pt % NUM_POINTS;
    for (int i = 0; i < 6; i++)
      strain_store[a][i] = sat(longint'(strain_store[a][i]) + incr_sum[i]);
    r.pt = n.pt;
    for (int i = 0; i < 3; i++)
      r.sig[i] = sat(kmul(k_normal, strain_store[a][i]) +
                     kmul(k_cross, strain_store[a][(i + 1) % 3]) +
                     kmul(k_cross, strain_store[a][(i + 2) % 3]));
    for (int i = 3; i < 6; i++) r.sig[i] = sat(kmul(k_shear, strain_store[a][i]));
    stress_q.push_back(r);
    incr_sum = '{default: 0};
    nodes_seen = 0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        accumulate_node(cur);
        accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (node_q.size() > 0 && ((accepted >= quiet_from && accepted < quiet_to) ||
                                  $urandom_range(99) >= 11)) begin
          cur = node_q.pop_front();
          s_tvalid <= 1'b1;
          s_tlast <= cur.last;
          s_tdata <= {7'd0, cur.grad[2], cur.grad[1], cur.grad[0], cur.mass,
                      cur.mom[2], cur.mom[1], cur.mom[0], cur.pt};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stress_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (stress_q.size() == 0) begin
          $error("stress transaction with nothing expected, point %0d", m_tdata[9:0]);
          errors++;
        end else begin
          e = stress_q.pop_front();
          points_done++;
          if (m_tdata[9:0] !== e.pt) begin
            $error("out_point: expected %0d, got %0d", e.pt, m_tdata[9:0]);
            errors++;
          end
          for (int i = 0; i < 6; i++)
            if ($signed(m_tdata[10 + 32*i +: 32]) !== e.sig[i]) begin
              $error("stress_%s: expected %0d, got %0d",
                     i == 0 ? "xx" : i == 1 ? "yy" : i == 2 ? "zz" :
                     i == 3 ? "xy" : i == 4 ? "yz" : "zx",
                     e.sig[i], $signed(m_tdata[10 + 32*i +: 32]));
              errors++;
            end
        end
      end
      m_tready <= (accepted >= quiet_from && accepted < quiet_to) ||
                  $urandom_range(99) >= 11;
    end
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(65536 * 4)) - 32'sd131072;
      default: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(5))
      0: return 31'($urandom());
      1: return mass_min[30:0] + 31'($urandom_range(2));
      2: return mass_min[30:0] - 31'($urandom_range(1));
      default: return 31'(mass_min) + 31'($urandom_range(65536 * 8));
    endcase
  endfunction

  function automatic node_t make_node(logic [9:0] pt, logic last);
    node_t n;
    n.pt = pt;
    n.last = last;
    n.mass = rand_mass();
    for (int i = 0; i < 3; i++) begin
      n.mom[i] = rand_val();
      n.grad[i] = rand_val();
    end
    return n;
  endfunction

  // one point: mostly well-formed, some full-length points with the last mark missing
  task automatic queue_point();
    logic [9:0] pt;
    int cnt;
    pt = $urandom_range(1) ? 10'($urandom_range(15)) : 10'($urandom());
    cnt = $urandom_range(9) == 0 ? NODES_PER_POINT : $urandom_range(1, NODES_PER_POINT);
    for (int i = 0; i < cnt; i++)
      node_q.push_back(make_node(pt, (i == cnt - 1) && (cnt < NODES_PER_POINT ||
                                                        $urandom_range(1))));
  endtask

  task automatic drain();
    while (node_q.size() > 0 || s_tvalid || stress_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_regs(longint unsigned n, longint unsigned c, longint unsigned s,
                            longint unsigned t, longint unsigned m);
    longint unsigned v [5];
    v = '{n, c, s, t, m};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= v[i][30:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    k_normal = v[REG_NORMAL]; k_cross = v[REG_CROSS]; k_shear = v[REG_SHEAR];
    dt = v[REG_DT]; mass_min = v[REG_THRESH];
  endtask

  initial begin
    node_t n;
    quiet_from = 700;
    quiet_to = 950;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_regs(64'd4 << 16, 64'd2 << 16, 64'd1 << 16, 64'd1 << 14, 64'd1 << 12);
    // directed: field extremes, skipped nodes, skipped last node, missing last mark
    n = make_node(10'd0, 1'b0);
    n.mass = 31'h7fffffff;
    n.mom = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    n.grad = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    node_q.push_back(n);
    n.mass = 31'((1 << 12) + 1);
    node_q.push_back(n);
    n.mom = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff};
    n.grad = '{32'sh00010000, -32'sh00010000, 32'sh00000000};
    node_q.push_back(n);
    n.mass = 31'd0;
    n.last = 1'b1;
    node_q.push_back(n);
    n = make_node(10'h3ff, 1'b1);
    n.mass = 31'(1 << 12);
    node_q.push_back(n);
    for (int i = 0; i < NODES_PER_POINT; i++) node_q.push_back(make_node(10'h3ff, 1'b0));
    n = make_node(10'h3ff, 1'b1);
    n.mom = '{32'sd0, 32'sd0, 32'sd0};
    node_q.push_back(n);
    drain();
    // random points; while accepted is between quiet_from and quiet_to, sender and sink never pause
    while (node_q.size() < 300) queue_point();
    drain();
    write_regs(64'h7fffffff, 64'h7fffffff, 64'h7fffffff, 64'h7fffffff, 64'd0);
    while (node_q.size() < 300) queue_point();
    drain();
    write_regs(0, 0, 0, 0, 64'h7fffffff);
    while (node_q.size() < 100) queue_point();
    drain();
    write_regs($urandom() >> 1, $urandom() >> 1, $urandom() >> 1, $urandom() >> 1,
               $urandom_range(65536 * 4));
    while (node_q.size() < 500) queue_point();
    drain();
    write_regs(64'd200 << 16, 64'd80 << 16, 64'd60 << 16, 64'd1 << 10, 64'd1);
    while (node_q.size() < 500) queue_point();
    drain();
    $display("covered %0d node transactions and %0d stress transactions", accepted,
             points_done);
    $display("over five stiffness, time step and threshold settings including extremes");
    if (errors == 0)
      $display("mpm_hooke_strain_stress_update_unit regression: pass");
    else
      $display("mpm_hooke_strain_stress_update_unit regression: fail");
    $finish;
  end

  initial begin
    #30ms;
    $display("mpm_hooke_strain_stress_update_unit regression: fail");
    $finish;
  end

endmodule
